FILE: src/bbvp_pkg.sv
// Shared types and constants of the basic block vector profiler.
package bbvp_pkg;
	localparam int TABLE_ENTRIES = 32;
	localparam int ADDR_W = 48;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int ID_W = 6;

	localparam logic [1:0] KIND_VECTOR = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_BREAK = 2'd2;

	localparam logic [1:0] REG_SLICE_LEN = 2'd0;
	localparam logic [1:0] REG_SKIP = 2'd1;
	localparam logic [1:0] REG_LEAD = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [11:0] size;
		logic [31:0] slice_cnt;
		logic [63:0] total_cnt;
	} cell_t;

	typedef struct packed {
		logic rotate;
		logic update;
	} cell_ctrl_t;
endpackage

FILE: src/bbvp_cell.sv
// One table entry: address match, counter update and rotation towards its neighbour.
module bbvp_cell (
	input  logic clk,
	input  bbvp_pkg::cell_ctrl_t ctrl,
	input  logic [bbvp_pkg::ID_W-1:0] cell_idx,
	input  logic [bbvp_pkg::ID_W-1:0] used,
	input  logic [bbvp_pkg::ADDR_W-1:0] pc,
	input  logic [11:0] size,
	input  bbvp_pkg::cell_t from_next,
	output bbvp_pkg::cell_t data,
	output logic hit
);
	import bbvp_pkg::*;

	cell_t data_q;
	logic in_use;
	logic alloc_here;

	assign in_use = cell_idx < used;
	assign hit = in_use && (data_q.addr == pc);
	assign alloc_here = (cell_idx == used);
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.rotate) begin
			data_q <= from_next;
		end else if (ctrl.update) begin
			if (hit) begin
				if (data_q.slice_cnt != 32'hFFFF_FFFF)
					data_q.slice_cnt <= data_q.slice_cnt + 32'd1;
				data_q.total_cnt <= data_q.total_cnt + 64'd1;
			end else if (alloc_here) begin
				data_q.addr <= pc;
				data_q.size <= size;
				data_q.slice_cnt <= 32'd1;
				data_q.total_cnt <= 64'd1;
			end
		end
	end
endmodule

FILE: src/basic_block_vector_profiler.sv
// Top level of the basic block vector profiler: sequencer, counters and the row of table cells.
// An ordinary block passes three steps from acceptance to the next acceptance (accept, table
// lookup and update, decision), plus one step when a breakpoint word is sent. A slice end adds a
// sweep that rotates the whole table of 32 cells through cell 0, one cell a cycle, holding while
// the cell must emit and the output holds a word the consumer has not yet taken, and then sends
// the slice-end word. Ids follow first execution.
module basic_block_vector_profiler (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [47:0] block_pc,
	input  logic [11:0] block_size,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [47:0] cfg_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] record_kind,
	output logic [5:0] entry_id,
	output logic [63:0] count_value,
	output logic [47:0] record_pc,
	output logic table_overflow,
	output logic last_of_run
);
	import bbvp_pkg::*;

	typedef enum logic [2:0] {IDLE, LOOK, DECIDE, SWEEP, SEND_END, SEND_BP} state_t;

	state_t state_q;
	logic [39:0] slice_len_q, lead_q;
	logic [47:0] skip_q;
	logic [63:0] total_q, slice_start_q, diff_q;
	logic bp_done_q, overflow_q;
	logic [ID_W-1:0] used_q;
	logic [IDX_W-1:0] rot_q;
	logic [ADDR_W-1:0] pc_q;
	logic [11:0] size_q;
	logic [TABLE_ENTRIES-1:0] hit_q;

	logic out_valid_q;
	logic [1:0] kind_q;
	logic [5:0] id_q;
	logic [63:0] cnt_q;
	logic [47:0] rpc_q;
	logic ovf_q, last_q;

	cell_t cells [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] hits;
	cell_ctrl_t ctrl;
	logic out_free, any_hit, past_skip, slice_end, bp_due, emit_here, load_out;
	logic [63:0] bp_cnt;

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			cell_t nxt;
			if (g == TABLE_ENTRIES - 1) begin : g_wrap
				always_comb begin
					nxt = cells[0];
					nxt.slice_cnt = '0;
				end
			end else begin : g_mid
				assign nxt = cells[g+1];
			end
			bbvp_cell u_cell (
				.clk(clk), .ctrl(ctrl), .cell_idx(ID_W'(g)), .used(used_q),
				.pc(pc_q), .size(size_q), .from_next(nxt), .data(cells[g]), .hit(hits[g])
			);
		end
	endgenerate

	assign in_ready = (state_q == IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign any_hit = |hits;
	assign past_skip = total_q > {16'd0, skip_q};
	assign slice_end = (diff_q > {24'd0, slice_len_q}) && past_skip;
	assign bp_due = (lead_q <= slice_len_q) && !bp_done_q && past_skip
		&& (diff_q > {24'd0, slice_len_q - lead_q});
	assign emit_here = ({1'b0, rot_q} < used_q) && (cells[0].slice_cnt != 32'd0);
	assign load_out = out_free && (((state_q == SWEEP) && emit_here)
		|| (state_q == SEND_END) || (state_q == SEND_BP));

	always_comb begin
		ctrl.update = (state_q == LOOK);
		ctrl.rotate = (state_q == SWEEP) && (!emit_here || out_free);
		bp_cnt = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (hit_q[i]) bp_cnt = bp_cnt | cells[i].total_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			slice_len_q <= 40'd50000000;
			skip_q <= '0;
			lead_q <= 40'd1000000;
			total_q <= '0;
			slice_start_q <= '0;
			bp_done_q <= 1'b0;
			overflow_q <= 1'b0;
			used_q <= '0;
			rot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SLICE_LEN: slice_len_q <= cfg_data[39:0];
					REG_SKIP: skip_q <= cfg_data;
					REG_LEAD: lead_q <= cfg_data[39:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && !load_out) out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						pc_q <= block_pc;
						size_q <= block_size;
						total_q <= total_q + 64'(block_size);
						state_q <= LOOK;
					end
				end
				LOOK: begin
					diff_q <= total_q - slice_start_q;
					if (any_hit) begin
						hit_q <= hits;
					end else if (used_q == ID_W'(TABLE_ENTRIES)) begin
						hit_q <= hits;
						overflow_q <= 1'b1;
					end else begin
						used_q <= used_q + 1'b1;
						hit_q <= TABLE_ENTRIES'(1) << used_q[IDX_W-1:0];
					end
					state_q <= DECIDE;
				end
				DECIDE: begin
					rot_q <= '0;
					if (slice_end) state_q <= SWEEP;
					else if (bp_due) state_q <= SEND_BP;
					else state_q <= IDLE;
				end
				SWEEP: begin
					if (!emit_here || out_free) begin
						if (emit_here) begin
							out_valid_q <= 1'b1;
							kind_q <= KIND_VECTOR;
							id_q <= 6'({1'b0, rot_q} + 6'd1);
							cnt_q <= 64'(cells[0].slice_cnt * {32'd0, cells[0].size});
							rpc_q <= '0;
							ovf_q <= 1'b0;
							last_q <= 1'b0;
						end
						rot_q <= rot_q + 1'b1;
						if (rot_q == IDX_W'(TABLE_ENTRIES - 1)) state_q <= SEND_END;
					end
				end
				SEND_END: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q <= KIND_END;
						id_q <= '0;
						cnt_q <= '0;
						rpc_q <= '0;
						ovf_q <= overflow_q;
						last_q <= 1'b1;
						slice_start_q <= total_q;
						bp_done_q <= 1'b0;
						state_q <= IDLE;
					end
				end
				SEND_BP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q <= KIND_BREAK;
						id_q <= '0;
						cnt_q <= bp_cnt;
						rpc_q <= pc_q;
						ovf_q <= 1'b0;
						last_q <= 1'b1;
						bp_done_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign record_kind = kind_q;
	assign entry_id = id_q;
	assign count_value = cnt_q;
	assign record_pc = rpc_q;
	assign table_overflow = ovf_q;
	assign last_of_run = last_q;

`ifndef SYNTH
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= ID_W'(TABLE_ENTRIES)) else $error("table fill count beyond depth");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == LOOK) else $error("accepted word not looked up");
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == LOOK |-> $onehot0(hits)) else $error("address matched in two cells");
	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DECIDE && slice_end |=> state_q == SWEEP && rot_q == '0)
		else $error("sweep did not start at cell 0");
`endif
endmodule
